// ===== rtl/scra_pkg.sv =====
// Shared types, constants and helpers for the scancode-to-ASCII ring buffer.
// Used by every module of the block and by its port checker.
// Depends on nothing.
`default_nettype none

package scra_pkg;

   // Sizes of the block's storage.
   localparam int BUFFER_DEPTH = 255;
   localparam int KEYMAP_DEPTH = 128;
   localparam int PTR_W        = $clog2(BUFFER_DEPTH);
   localparam int COUNT_W      = $clog2(BUFFER_DEPTH + 1);
   localparam int KEY_W        = $clog2(KEYMAP_DEPTH);

   // Field widths.
   localparam int CHAR_W      = 8;
   localparam int CODE_W      = 8;
   localparam int FUNC_W      = 3;
   localparam int STATUS_W    = 2;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // Queue between the front and back ends.
   localparam int QUEUE_DEPTH   = 2;
   localparam int QUEUE_PTR_W   = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_COUNT_W = $clog2(QUEUE_DEPTH + 1);

   // Function codes on req_func.
   localparam logic [FUNC_W-1:0] FUNC_SCAN      = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ      = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_PEEK      = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_BACK = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_LOAD      = 3'd4;

   // Configuration register indexes and reset values.
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_PRESS   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SHIFT_RELEASE = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_CAPS_TOGGLE   = 2'd2;
   localparam logic [CODE_W-1:0] SHIFT_PRESS_RESET   = 8'd42;
   localparam logic [CODE_W-1:0] SHIFT_RELEASE_RESET = 8'd170;
   localparam logic [CODE_W-1:0] CAPS_TOGGLE_RESET   = 8'd58;

   // Result status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_IGNORED = 2'd2;

   // Character constants.
   localparam logic [CHAR_W-1:0] EMPTY_CHAR = 8'hFF;
   localparam logic [CODE_W-1:0] HIGH_CODE  = 8'h80;
   localparam logic [CHAR_W-1:0] UPPER_A    = 8'd65;
   localparam logic [CHAR_W-1:0] UPPER_Z    = 8'd90;
   localparam logic [CHAR_W-1:0] LOWER_A    = 8'd97;
   localparam logic [CHAR_W-1:0] LOWER_Z    = 8'd122;

   // Operation a transaction performs once classified.
   typedef enum logic [2:0] {
      OP_SCAN,
      OP_SCAN_HIGH,
      OP_READ,
      OP_PEEK,
      OP_PUSH_BACK,
      OP_LOAD,
      OP_NOP
   } op_type;

   // Effect of a scancode on the shift and caps flags.
   typedef enum logic [1:0] {
      FLAG_NONE,
      FLAG_SHIFT_SET,
      FLAG_SHIFT_CLR,
      FLAG_CAPS_TOGGLE
   } flag_type;

   // One classified transaction as it travels through the queue.
   typedef struct packed {
      op_type              op;
      flag_type            flag;
      logic [KEY_W-1:0]    key_index;
      logic [CHAR_W-1:0]   char_in;
      logic                map_shifted;
   } job_type;

   // What the queue shows to the back end.
   typedef struct packed {
      logic    empty;
      job_type head;
   } queue_status_type;

   // Back-end sequencer states.
   typedef enum logic {
      BACK_IDLE,
      BACK_FINISH
   } back_state_type;

   function automatic logic is_letter(input logic [CHAR_W-1:0] c);
      return ((c >= UPPER_A) && (c <= UPPER_Z)) || ((c >= LOWER_A) && (c <= LOWER_Z));
   endfunction

endpackage

`default_nettype wire

// ===== rtl/scra_front.sv =====
// Front end: holds the configuration registers and classifies each request.
// Depends on scra_pkg.
`default_nettype none

module scra_front (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [scra_pkg::FUNC_W-1:0]     req_func,
   input  wire logic [scra_pkg::CODE_W-1:0]     req_scancode,
   input  wire logic [scra_pkg::CHAR_W-1:0]     req_char_in,
   input  wire logic [scra_pkg::KEY_W-1:0]      req_map_index,
   input  wire logic                            req_map_shifted,
   input  wire logic                            csr_write_enable,
   input  wire logic [scra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [scra_pkg::CSR_DATA_W-1:0] csr_wdata,
   input  wire logic                            queue_full,
   output logic                                 push,
   output scra_pkg::job_type                    push_job
);
   import scra_pkg::*;

   logic [CODE_W-1:0] shift_press_ff;
   logic [CODE_W-1:0] shift_release_ff;
   logic [CODE_W-1:0] caps_toggle_ff;

   // Configuration writes are registered and apply to requests taken after the write.
   always_ff @(posedge clock) begin
      if (reset) begin
         shift_press_ff   <= SHIFT_PRESS_RESET;
         shift_release_ff <= SHIFT_RELEASE_RESET;
         caps_toggle_ff   <= CAPS_TOGGLE_RESET;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SHIFT_PRESS:   shift_press_ff   <= csr_wdata;
            CSR_SHIFT_RELEASE: shift_release_ff <= csr_wdata;
            CSR_CAPS_TOGGLE:   caps_toggle_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // A transaction is taken whenever start is high and the queue has room.
   assign push = start && !queue_full;

   // Classify the request into an operation and a flag effect.
   always_comb begin
      push_job.op          = OP_NOP;
      push_job.flag        = FLAG_NONE;
      push_job.key_index   = req_scancode[KEY_W-1:0];
      push_job.char_in     = req_char_in;
      push_job.map_shifted = req_map_shifted;
      case (req_func)
         FUNC_SCAN: begin
            push_job.op = (req_scancode >= HIGH_CODE) ? OP_SCAN_HIGH : OP_SCAN;
            // Only the first matching code acts, press before release before caps.
            if (req_scancode == shift_press_ff) begin
               push_job.flag = FLAG_SHIFT_SET;
            end else if (req_scancode == shift_release_ff) begin
               push_job.flag = FLAG_SHIFT_CLR;
            end else if (req_scancode == caps_toggle_ff) begin
               push_job.flag = FLAG_CAPS_TOGGLE;
            end
         end
         FUNC_READ:      push_job.op = OP_READ;
         FUNC_PEEK:      push_job.op = OP_PEEK;
         FUNC_PUSH_BACK: push_job.op = OP_PUSH_BACK;
         FUNC_LOAD: begin
            push_job.op        = OP_LOAD;
            push_job.key_index = req_map_index;
         end
         default:        push_job.op = OP_NOP;
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/scra_queue.sv =====
// Short queue of classified transactions between the front and back ends.
// Depends on scra_pkg.
`default_nettype none

module scra_queue (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   push,
   input  wire scra_pkg::job_type      push_job,
   input  wire logic                   pop,
   output scra_pkg::queue_status_type  queue_status,
   output logic                        full
);
   import scra_pkg::*;

   job_type                  entry_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff;
   logic [QUEUE_COUNT_W-1:0] count_ff;
   logic                     do_push;
   logic                     do_pop;

   assign full    = (count_ff == QUEUE_COUNT_W'(QUEUE_DEPTH));
   assign do_push = push && !full;
   assign do_pop  = pop && (count_ff != '0);

   assign queue_status.empty = (count_ff == '0);
   assign queue_status.head  = entry_ff[rd_ptr_ff];

   // Entry storage carries payload only.
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   // Pointers and fill count; the depth is a power of two so pointers wrap freely.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

`default_nettype wire

// ===== rtl/scra_back.sv =====
// Back end: keymap and character memories, flags, ring pointers and results.
// Depends on scra_pkg.
`default_nettype none

module scra_back (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire scra_pkg::queue_status_type    queue_status,
   output logic                               pop,
   output logic                               rsp_valid,
   output logic [scra_pkg::CHAR_W-1:0]        rsp_char_out,
   output logic [scra_pkg::STATUS_W-1:0]      rsp_status
);
   import scra_pkg::*;

   back_state_type state_ff;
   back_state_type state_in;

   // Memories.
   logic [CHAR_W-1:0] plain_map_ff   [KEYMAP_DEPTH];
   logic [CHAR_W-1:0] shifted_map_ff [KEYMAP_DEPTH];
   logic [CHAR_W-1:0] store_ff       [BUFFER_DEPTH];
   logic [BUFFER_DEPTH-1:0] store_valid_ff;

   // Registered read data.
   logic [CHAR_W-1:0] plain_rd_ff;
   logic [CHAR_W-1:0] shifted_rd_ff;
   logic [CHAR_W-1:0] store_rd_ff;
   logic              store_rd_valid_ff;

   // Transaction in flight.
   job_type job_ff;

   // Flags and ring state.
   logic               shift_ff;
   logic               shift_in;
   logic               caps_ff;
   logic               caps_in;
   logic [PTR_W-1:0]   write_ptr_ff;
   logic [PTR_W-1:0]   write_ptr_in;
   logic [PTR_W-1:0]   read_ptr_ff;
   logic [PTR_W-1:0]   read_ptr_in;
   logic [COUNT_W-1:0] count_ff;
   logic [COUNT_W-1:0] count_in;

   // Result registers.
   logic                rsp_valid_ff;
   logic                rsp_valid_in;
   logic [CHAR_W-1:0]   rsp_char_ff;
   logic [CHAR_W-1:0]   rsp_char_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [STATUS_W-1:0] rsp_status_in;

   // Sequencer outputs.
   logic read_phase;
   logic finish;

   // Memory write controls.
   logic              store_we;
   logic [PTR_W-1:0]  store_wr_addr;
   logic [CHAR_W-1:0] store_wr_data;
   logic              map_we;
   logic [PTR_W-1:0]  store_rd_addr;

   // Helpers.
   logic [PTR_W-1:0]   last_ptr;
   logic [PTR_W-1:0]   write_ptr_inc;
   logic [PTR_W-1:0]   read_ptr_inc;
   logic [PTR_W-1:0]   read_ptr_dec;
   logic [COUNT_W-1:0] count_up;
   logic [CHAR_W-1:0]  lookup_char;
   logic [CHAR_W-1:0]  stored_char;

   // Next state of the two-step sequencer: fetch, then finish.
   always_comb begin
      case (state_ff)
         BACK_IDLE:   state_in = queue_status.empty ? BACK_IDLE : BACK_FINISH;
         BACK_FINISH: state_in = BACK_IDLE;
         default:     state_in = BACK_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      read_phase = 1'b0;
      finish     = 1'b0;
      case (state_ff)
         BACK_IDLE:   read_phase = !queue_status.empty;
         BACK_FINISH: finish     = 1'b1;
         default: ;
      endcase
   end

   assign pop = read_phase;

   // Ring pointer arithmetic with wrap at the buffer depth.
   assign last_ptr      = (write_ptr_ff == '0) ? PTR_W'(BUFFER_DEPTH - 1) : write_ptr_ff - 1'b1;
   assign write_ptr_inc = (write_ptr_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : write_ptr_ff + 1'b1;
   assign read_ptr_inc  = (read_ptr_ff == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : read_ptr_ff + 1'b1;
   assign read_ptr_dec  = (read_ptr_ff == '0) ? PTR_W'(BUFFER_DEPTH - 1) : read_ptr_ff - 1'b1;
   assign count_up      = (count_ff == COUNT_W'(BUFFER_DEPTH)) ? '0 : count_ff + 1'b1;

   assign store_rd_addr = (queue_status.head.op == OP_PEEK) ? last_ptr : read_ptr_ff;

   // Keymap memories: both maps are read at the same index in the fetch step.
   always_ff @(posedge clock) begin
      if (map_we && job_ff.map_shifted) begin
         shifted_map_ff[job_ff.key_index] <= job_ff.char_in;
      end
      if (map_we && !job_ff.map_shifted) begin
         plain_map_ff[job_ff.key_index] <= job_ff.char_in;
      end
      if (read_phase) begin
         plain_rd_ff   <= plain_map_ff[queue_status.head.key_index];
         shifted_rd_ff <= shifted_map_ff[queue_status.head.key_index];
      end
   end

   // Character store: one write in the finish step, one read in the fetch step.
   always_ff @(posedge clock) begin
      if (store_we) begin
         store_ff[store_wr_addr] <= store_wr_data;
      end
      if (read_phase) begin
         store_rd_ff <= store_ff[store_rd_addr];
      end
   end

   // Written marks make never-written entries read as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         store_valid_ff    <= '0;
         store_rd_valid_ff <= 1'b0;
      end else begin
         if (store_we) begin
            store_valid_ff[store_wr_addr] <= 1'b1;
         end
         if (read_phase) begin
            store_rd_valid_ff <= store_valid_ff[store_rd_addr];
         end
      end
   end

   // Latch the popped transaction.
   always_ff @(posedge clock) begin
      if (read_phase) begin
         job_ff <= queue_status.head;
      end
   end

   // Flags change as the scancode is fetched, so the lookup sees the new shift.
   always_comb begin
      shift_in = shift_ff;
      caps_in  = caps_ff;
      if (read_phase) begin
         case (queue_status.head.flag)
            FLAG_SHIFT_SET:   shift_in = 1'b1;
            FLAG_SHIFT_CLR:   shift_in = 1'b0;
            FLAG_CAPS_TOGGLE: caps_in  = !caps_ff;
            default: ;
         endcase
      end
   end

   // Translation: caps lock takes the other map only for letters.
   always_comb begin
      lookup_char = shift_ff ? shifted_rd_ff : plain_rd_ff;
      if (caps_ff && is_letter(lookup_char)) begin
         lookup_char = shift_ff ? plain_rd_ff : shifted_rd_ff;
      end
   end

   assign stored_char = store_rd_valid_ff ? store_rd_ff : '0;

   // Finish step: memory writes, ring updates and the result.
   always_comb begin
      write_ptr_in  = write_ptr_ff;
      read_ptr_in   = read_ptr_ff;
      count_in      = count_ff;
      store_we      = 1'b0;
      store_wr_addr = write_ptr_ff;
      store_wr_data = lookup_char;
      map_we        = 1'b0;
      rsp_valid_in  = finish;
      rsp_char_in   = '0;
      rsp_status_in = STATUS_OK;
      if (finish) begin
         case (job_ff.op)
            OP_SCAN: begin
               store_we     = 1'b1;
               write_ptr_in = write_ptr_inc;
               count_in     = count_up;
               rsp_char_in  = lookup_char;
            end
            OP_SCAN_HIGH: begin
               rsp_status_in = STATUS_IGNORED;
            end
            OP_READ: begin
               if (count_ff == '0) begin
                  rsp_char_in   = EMPTY_CHAR;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_char_in = stored_char;
                  read_ptr_in = read_ptr_inc;
                  count_in    = count_ff - 1'b1;
               end
            end
            OP_PEEK: begin
               if (count_ff == '0) begin
                  rsp_char_in   = EMPTY_CHAR;
                  rsp_status_in = STATUS_EMPTY;
               end else begin
                  rsp_char_in = stored_char;
               end
            end
            OP_PUSH_BACK: begin
               store_we      = 1'b1;
               store_wr_addr = read_ptr_dec;
               store_wr_data = job_ff.char_in;
               read_ptr_in   = read_ptr_dec;
               count_in      = count_up;
            end
            OP_LOAD: begin
               map_we = 1'b1;
            end
            default: ;
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= BACK_IDLE;
         shift_ff      <= 1'b0;
         caps_ff       <= 1'b0;
         write_ptr_ff  <= '0;
         read_ptr_ff   <= '0;
         count_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         shift_ff      <= shift_in;
         caps_ff       <= caps_in;
         write_ptr_ff  <= write_ptr_in;
         read_ptr_ff   <= read_ptr_in;
         count_ff      <= count_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      rsp_char_ff   <= rsp_char_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_char_out = rsp_char_ff;
   assign rsp_status   = rsp_status_ff;

endmodule

`default_nettype wire

// ===== rtl/scancode_to_ascii_ring_buffer.sv =====
// Scancode-to-ASCII translator with a character ring buffer, top level.
// rsp_valid is registered: a transaction passes the queue, then the back end's fetch
// and finish steps; each transaction still queued ahead delays its result further.
// The back end ends one transaction before taking the next, in its fetch-then-finish
// sequence on the keymap and character memories; busy is high while the two-entry
// queue is full. The receiver cannot stall, so results never wait.
// Reset (synchronous) restores the codes, flags, pointers and count; keymaps hold no reset.
`default_nettype none

module scancode_to_ascii_ring_buffer (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   output logic                                  busy,
   input  wire logic [scra_pkg::FUNC_W-1:0]      req_func,
   input  wire logic [scra_pkg::CODE_W-1:0]      req_scancode,
   input  wire logic [scra_pkg::CHAR_W-1:0]      req_char_in,
   input  wire logic [scra_pkg::KEY_W-1:0]       req_map_index,
   input  wire logic                             req_map_shifted,
   output logic                                  rsp_valid,
   output logic [scra_pkg::CHAR_W-1:0]           rsp_char_out,
   output logic [scra_pkg::STATUS_W-1:0]         rsp_status,
   input  wire logic                             csr_write_enable,
   input  wire logic [scra_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [scra_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import scra_pkg::*;

   logic             push;
   job_type          push_job;
   logic             pop;
   logic             queue_full;
   queue_status_type queue_status;

   assign busy = queue_full;

   // Front end: configuration and classification.
   scra_front u_front (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .req_func         (req_func),
      .req_scancode     (req_scancode),
      .req_char_in      (req_char_in),
      .req_map_index    (req_map_index),
      .req_map_shifted  (req_map_shifted),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .queue_full       (queue_full),
      .push             (push),
      .push_job         (push_job)
   );

   // Queue between the two halves.
   scra_queue u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_job     (push_job),
      .pop          (pop),
      .queue_status (queue_status),
      .full         (queue_full)
   );

   // Back end: execution and results.
   scra_back u_back (
      .clock        (clock),
      .reset        (reset),
      .queue_status (queue_status),
      .pop          (pop),
      .rsp_valid    (rsp_valid),
      .rsp_char_out (rsp_char_out),
      .rsp_status   (rsp_status)
   );

endmodule

`default_nettype wire

// ===== rtl/scra_checker.sv =====
// Port-level checks for the scancode-to-ASCII ring buffer, bound to the top level.
// Depends on scra_pkg and scancode_to_ascii_ring_buffer.
`default_nettype none

module scra_checker (
   input wire logic                        clock,
   input wire logic                        reset,
   input wire logic                        rsp_valid,
   input wire logic [scra_pkg::CHAR_W-1:0] rsp_char_out,
   input wire logic [scra_pkg::STATUS_W-1:0] rsp_status
);
   import scra_pkg::*;

   // The back end fetches between any two finish steps, so strobes are never adjacent.
   a_no_back_to_back: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobes in consecutive cycles");

   // An empty buffer answers with the empty character.
   a_empty_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_EMPTY)) |-> (rsp_char_out == EMPTY_CHAR))
      else $error("empty status without the empty character");

   // An ignored scancode pushes nothing and reports zero.
   a_ignored_char: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status == STATUS_IGNORED)) |-> (rsp_char_out == '0))
      else $error("ignored scancode with a nonzero character");

   // Only the three defined status codes ever appear.
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == STATUS_OK) || (rsp_status == STATUS_EMPTY) ||
                     (rsp_status == STATUS_IGNORED)))
      else $error("undefined status code");

   // No result comes out of reset.
   a_quiet_after_reset: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result strobe right after reset");

endmodule

bind scancode_to_ascii_ring_buffer scra_checker u_scra_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_char_out (rsp_char_out),
   .rsp_status   (rsp_status)
);

`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for scancode_to_ascii_ring_buffer: a queue-fed driver, a monitor
// that predicts and checks each result, and phases that walk the shift and caps lock codes.
// Depends on scra_pkg and the scancode_to_ascii_ring_buffer RTL.

module testbench;
   import scra_pkg::*;

   localparam int RESET_CYCLES = 8;
   localparam int DRAIN_CYCLES = 8;
   localparam int STALL_LIMIT  = 1000;
   localparam int IDLE_PCT     = 24;
   localparam int CODE_BIAS    = 20;
   localparam int ANY          = -1;

   // Function codes the block treats as no operation.
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI = 3'd7;

   // Two keys with known keymap entries for the directed checks.
   localparam logic [KEY_W-1:0]  KEY_LETTER = 7'h1E;
   localparam logic [KEY_W-1:0]  KEY_DIGIT  = 7'h02;
   localparam logic [CHAR_W-1:0] DIGIT_ONE  = 8'h31;
   localparam logic [CHAR_W-1:0] BANG       = 8'h21;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [CODE_W-1:0] scancode;
      logic [CHAR_W-1:0] char_in;
      logic [KEY_W-1:0]  map_index;
      logic              map_shifted;
   } key_event_type;

   typedef struct packed {
      logic [CHAR_W-1:0]   char_out;
      logic [STATUS_W-1:0] status;
   } char_result_type;

   logic                   clock            = 1'b0;
   logic                   reset            = 1'b1;
   logic                   start            = 1'b0;
   logic                   busy;
   logic [FUNC_W-1:0]      req_func         = '0;
   logic [CODE_W-1:0]      req_scancode     = '0;
   logic [CHAR_W-1:0]      req_char_in      = '0;
   logic [KEY_W-1:0]       req_map_index    = '0;
   logic                   req_map_shifted  = 1'b0;
   logic                   rsp_valid;
   logic [CHAR_W-1:0]      rsp_char_out;
   logic [STATUS_W-1:0]    rsp_status;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index        = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata        = '0;

   // Stimulus and expectation stores.
   key_event_type   pending_keys[$];
   char_result_type awaited_chars[$];
   logic [CODE_W-1:0] code_set [3];
   bit quiet_run = 1'b0;

   // Shadow of the block's state, updated on each accepted transaction.
   logic [CODE_W-1:0] shadow_press, shadow_release, shadow_caps_code;
   logic              shadow_shift, shadow_caps;
   logic [CHAR_W-1:0] ring [BUFFER_DEPTH];
   logic [CHAR_W-1:0] plain_keys [KEYMAP_DEPTH];
   logic [CHAR_W-1:0] shifted_keys [KEYMAP_DEPTH];
   int ring_wr, ring_rd, unread;

   // Run statistics.
   int mismatches = 0;
   int checked    = 0;
   int accepted   = 0;
   int overflows  = 0;
   int max_unread = 0;
   int settings   = 0;
   int stall_cycles = 0;

   scancode_to_ascii_ring_buffer i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_func         (req_func),
      .req_scancode     (req_scancode),
      .req_char_in      (req_char_in),
      .req_map_index    (req_map_index),
      .req_map_shifted  (req_map_shifted),
      .rsp_valid        (rsp_valid),
      .rsp_char_out     (rsp_char_out),
      .rsp_status       (rsp_status),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic alpha_char(input logic [CHAR_W-1:0] c);
      return (c >= UPPER_A && c <= UPPER_Z) || (c >= LOWER_A && c <= LOWER_Z);
   endfunction

   // The unread count wraps to zero once it would pass the ring depth.
   function automatic void bump_unread();
      unread++;
      if (unread > BUFFER_DEPTH) begin
         unread = 0;
         overflows++;
      end
      if (unread > max_unread) max_unread = unread;
   endfunction

   // Applies one transaction to the shadow state and returns the result it causes.
   function automatic char_result_type translate_key_event(input key_event_type ev);
      char_result_type res;
      logic [CHAR_W-1:0] c;
      logic [KEY_W-1:0] k;
      res.char_out = '0;
      res.status   = STATUS_OK;
      k = ev.scancode[KEY_W-1:0];
      case (ev.func)
         FUNC_SCAN: begin
            if (ev.scancode == shadow_press) shadow_shift = 1'b1;
            else if (ev.scancode == shadow_release) shadow_shift = 1'b0;
            else if (ev.scancode == shadow_caps_code) shadow_caps = !shadow_caps;
            if (ev.scancode >= HIGH_CODE) begin
               res.status = STATUS_IGNORED;
            end else begin
               c = shadow_shift ? shifted_keys[k] : plain_keys[k];
               // Caps lock picks the other map only for letters.
               if (shadow_caps && alpha_char(c)) c = shadow_shift ? plain_keys[k] : shifted_keys[k];
               ring[ring_wr] = c;
               ring_wr = (ring_wr + 1) % BUFFER_DEPTH;
               bump_unread();
               res.char_out = c;
            end
         end
         FUNC_READ, FUNC_PEEK: begin
            if (unread == 0) begin
               res.char_out = EMPTY_CHAR;
               res.status   = STATUS_EMPTY;
            end else if (ev.func == FUNC_READ) begin
               res.char_out = ring[ring_rd];
               ring_rd = (ring_rd + 1) % BUFFER_DEPTH;
               unread--;
            end else begin
               res.char_out = ring[(ring_wr == 0) ? BUFFER_DEPTH - 1 : ring_wr - 1];
            end
         end
         FUNC_PUSH_BACK: begin
            ring_rd = (ring_rd == 0) ? BUFFER_DEPTH - 1 : ring_rd - 1;
            bump_unread();
            ring[ring_rd] = ev.char_in;
         end
         FUNC_LOAD: begin
            if (ev.map_shifted) shifted_keys[ev.map_index] = ev.char_in;
            else plain_keys[ev.map_index] = ev.char_in;
         end
         default: ;
      endcase
      return res;
   endfunction

   // Builds a transaction; fields given as ANY get random values.
   function automatic key_event_type make_event(input logic [FUNC_W-1:0] func, input int code,
                                                input int cin, input int idx, input int shifted);
      key_event_type ev;
      ev.func        = func;
      ev.scancode    = (code < 0) ? CODE_W'($urandom) : CODE_W'(code);
      ev.char_in     = (cin < 0) ? CHAR_W'($urandom) : CHAR_W'(cin);
      ev.map_index   = (idx < 0) ? KEY_W'($urandom) : KEY_W'(idx);
      ev.map_shifted = (shifted < 0) ? 1'($urandom) : 1'(shifted);
      return ev;
   endfunction

   // Keymap contents lean toward letters so that caps lock matters often.
   function automatic logic [CHAR_W-1:0] random_map_char();
      case ($urandom_range(3))
         0: return CHAR_W'($urandom_range(UPPER_Z, UPPER_A));
         1: return CHAR_W'($urandom_range(LOWER_Z, LOWER_A));
         default: return CHAR_W'($urandom);
      endcase
   endfunction

   // Random transaction from a weighted mix; what is left of 100 goes to spare codes.
   function automatic key_event_type random_item(input int scan_w, input int read_w,
                                                 input int peek_w, input int back_w,
                                                 input int load_w, input int high_pct);
      key_event_type ev;
      int r;
      ev = make_event(FUNC_SCAN, ANY, ANY, ANY, ANY);
      r = $urandom_range(99);
      if (r < scan_w) begin
         r = $urandom_range(99);
         if (r < CODE_BIAS) ev.scancode = code_set[$urandom_range(2)];
         else if (r < CODE_BIAS + high_pct) ev.scancode = CODE_W'($urandom_range(255, HIGH_CODE));
         else ev.scancode = CODE_W'($urandom_range(HIGH_CODE - 1, 0));
      end else if (r < scan_w + read_w) begin
         ev.func = FUNC_READ;
      end else if (r < scan_w + read_w + peek_w) begin
         ev.func = FUNC_PEEK;
      end else if (r < scan_w + read_w + peek_w + back_w) begin
         ev.func = FUNC_PUSH_BACK;
      end else if (r < scan_w + read_w + peek_w + back_w + load_w) begin
         ev.func = FUNC_LOAD;
         ev.char_in = random_map_char();
      end else begin
         ev.func = FUNC_W'($urandom_range(FUNC_SPARE_HI, FUNC_SPARE_LO));
      end
      return ev;
   endfunction

   // Driver: once the slot is free, presents the next pending transaction, idling at random unless the phase is quiet.
   always @(posedge clock) begin : driver
      key_event_type ev;
      if (reset) begin
         start <= 1'b0;
      end else if (!start || !busy) begin
         if (pending_keys.size() != 0 && (quiet_run || $urandom_range(99) >= IDLE_PCT)) begin
            ev = pending_keys.pop_front();
            start           <= 1'b1;
            req_func        <= ev.func;
            req_scancode    <= ev.scancode;
            req_char_in     <= ev.char_in;
            req_map_index   <= ev.map_index;
            req_map_shifted <= ev.map_shifted;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: checks each result against the oldest expectation, then predicts new ones.
   always @(posedge clock) begin : monitor
      char_result_type want;
      key_event_type seen;
      logic took;
      if (reset) begin
         shadow_press     = SHIFT_PRESS_RESET;
         shadow_release   = SHIFT_RELEASE_RESET;
         shadow_caps_code = CAPS_TOGGLE_RESET;
         shadow_shift     = 1'b0;
         shadow_caps      = 1'b0;
         for (int i = 0; i < BUFFER_DEPTH; i++) ring[i] = '0;
         ring_wr      = 0;
         ring_rd      = 0;
         unread       = 0;
         stall_cycles = 0;
      end else begin
         took = start && !busy;
         if (rsp_valid) begin
            if (awaited_chars.size() == 0) begin
               $error("Unexpected result: char_out 0x%02h status %0d", rsp_char_out, rsp_status);
               mismatches++;
            end else begin
               want = awaited_chars.pop_front();
               if (rsp_char_out !== want.char_out) begin
                  $error("char_out: expected 0x%02h, actual 0x%02h", want.char_out, rsp_char_out);
                  mismatches++;
               end
               if (rsp_status !== want.status) begin
                  $error("status: expected %0d, actual %0d", want.status, rsp_status);
                  mismatches++;
               end
               checked++;
            end
         end

         // Register writes take effect for transactions accepted after this edge.
         if (csr_write_enable) begin
            case (csr_index)
               CSR_SHIFT_PRESS:   shadow_press     = csr_wdata;
               CSR_SHIFT_RELEASE: shadow_release   = csr_wdata;
               CSR_CAPS_TOGGLE:   shadow_caps_code = csr_wdata;
               default: ;
            endcase
         end

         if (took) begin
            seen.func        = req_func;
            seen.scancode    = req_scancode;
            seen.char_in     = req_char_in;
            seen.map_index   = req_map_index;
            seen.map_shifted = req_map_shifted;
            awaited_chars.push_back(translate_key_event(seen));
            accepted++;
         end

         // Watchdog on cycles in which neither side moves a transaction.
         if (took || rsp_valid) stall_cycles = 0;
         else stall_cycles++;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("Watchdog: no transaction for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   // Waits until the sender is drained and every result has come, then lets the pipe settle.
   task automatic wait_for_quiet();
      do @(negedge clock);
      while (pending_keys.size() != 0 || start || awaited_chars.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic write_code(input logic [CSR_INDEX_W-1:0] idx, input logic [CODE_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_wdata        <= value;
   endtask

   // One random phase: drain, program the three codes, then queue the mix.
   task automatic run_phase(input logic [CODE_W-1:0] press, input logic [CODE_W-1:0] release_code,
                            input logic [CODE_W-1:0] caps, input int count, input bit quiet,
                            input int scan_w, input int read_w, input int peek_w,
                            input int back_w, input int load_w, input int high_pct);
      wait_for_quiet();
      write_code(CSR_SHIFT_PRESS, press);
      write_code(CSR_SHIFT_RELEASE, release_code);
      write_code(CSR_CAPS_TOGGLE, caps);
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      code_set[0] = press;
      code_set[1] = release_code;
      code_set[2] = caps;
      quiet_run   = quiet;
      settings++;
      repeat (count)
         pending_keys.push_back(random_item(scan_w, read_w, peek_w, back_w, load_w, high_pct));
   endtask

   initial begin : stimulus
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      settings = 1;

      // Both keymaps are loaded in full before any scancode can look them up.
      for (int k = 0; k < KEYMAP_DEPTH; k++) begin
         pending_keys.push_back(make_event(FUNC_LOAD, ANY, int'(random_map_char()), k, 0));
         pending_keys.push_back(make_event(FUNC_LOAD, ANY, int'(random_map_char()), k, 1));
      end

      // Directed: known keys, empty ring, push back across the wrap, flag codes.
      pending_keys.push_back(make_event(FUNC_LOAD, ANY, int'(LOWER_A), int'(KEY_LETTER), 0));
      pending_keys.push_back(make_event(FUNC_LOAD, ANY, int'(UPPER_A), int'(KEY_LETTER), 1));
      pending_keys.push_back(make_event(FUNC_LOAD, ANY, int'(DIGIT_ONE), int'(KEY_DIGIT), 0));
      pending_keys.push_back(make_event(FUNC_LOAD, ANY, int'(BANG), int'(KEY_DIGIT), 1));
      pending_keys.push_back(make_event(FUNC_READ, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_PEEK, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_PUSH_BACK, ANY, 0, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_PUSH_BACK, ANY, 255, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_READ, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_READ, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, 0, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(HIGH_CODE) - 1, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(HIGH_CODE), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, 255, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(KEY_LETTER), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(SHIFT_PRESS_RESET), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(KEY_LETTER), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(CAPS_TOGGLE_RESET), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(KEY_LETTER), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(KEY_DIGIT), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(SHIFT_RELEASE_RESET), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SCAN, int'(KEY_LETTER), ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_PEEK, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SPARE_LO, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_SPARE_HI, ANY, ANY, ANY, ANY));
      pending_keys.push_back(make_event(FUNC_LOAD, ANY, 255, KEYMAP_DEPTH - 1, 1));
      pending_keys.push_back(make_event(FUNC_LOAD, ANY, 0, 0, 0));

      // Random phases: extreme codes with no idling, all codes equal while the ring
      // overflows, a read-heavy drain, then the reset codes again.
      run_phase(8'h00, 8'hFF, CODE_W'(HIGH_CODE - 1), 60, 1'b1, 45, 20, 10, 10, 10, 25);
      run_phase(8'h05, 8'h05, 8'h05, 260, 1'b0, 80, 1, 1, 17, 1, 0);
      run_phase(8'hFF, 8'h00, 8'h00, 50, 1'b0, 30, 50, 10, 5, 3, 25);
      run_phase(SHIFT_PRESS_RESET, SHIFT_RELEASE_RESET, CAPS_TOGGLE_RESET, 50, 1'b0,
                45, 20, 10, 10, 10, 25);
      wait_for_quiet();

      $display("Checked %0d results from %0d transactions under %0d code settings.",
               checked, accepted, settings);
      $display("Ring overflows %0d, deepest unread count %0d.", overflows, max_unread);
      if (mismatches == 0 && awaited_chars.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/scra_pkg.sv
rtl/scra_front.sv
rtl/scra_queue.sv
rtl/scra_back.sv
rtl/scancode_to_ascii_ring_buffer.sv
rtl/scra_checker.sv
test/testbench.sv
